// ===== design/i2cra_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C register access master package
// Shared types, opcodes and constants of the front end, queue and bus engine.
// ----------------------------------------------------------------------------
package i2cra_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic REG_BCD_CONVERT    = 1'b1;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd104;
  localparam logic       BCD_CONVERT_RESET    = 1'b1;
  localparam logic [6:0] BCD_MAX              = 7'd99;
  localparam logic [7:0] MASKED_REGISTER      = 8'd2;
  localparam logic [7:0] MASKED_READ_BITS     = 8'h3f;

  typedef struct packed {
    logic       is_cmd;
    logic       is_read;
    logic [7:0] reg_addr;
    logic [7:0] value;
    logic       sda;
  } item_t;

endpackage

// ===== design/i2c_register_access_master.sv =====
// ----------------------------------------------------------------------------
// I2C register access master
// Pin-level I2C master for one-byte register writes and reads with BCD mode.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                   Payload
// s_axis   in         tvalid/tready               tuser op, tdata reg/value/sda
// m_axis   out        tvalid/tready               tdata lines, status, read byte
// apb      in         psel/penable/pwrite/pready  device address, BCD enable
//
// The block takes one transaction per clock while the queue has room and returns one result per item.
// An accepted item passes through the queue and then the output register.
// The bus engine runs one sequencer step per item, which sets the rate.
// Reset leaves the bus idle with both lines released.
// A stalled output fills the queue (two entries by default), then tready drops.
// ----------------------------------------------------------------------------
module i2c_register_access_master
  import i2cra_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // reg_addr[7:0], write_value[15:8], sda_sample[16]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // scl, sda, busy, done, read_value[11:4], nack[12]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [6:0] device_address_q;
  logic       bcd_convert_q;
  item_t      front_item;
  item_t      queue_item;
  logic       queue_full;
  logic       queue_empty;
  logic       queue_pop;
  logic       push;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_BCD_CONVERT) ? {31'd0, bcd_convert_q}
                                                   : {25'd0, device_address_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_address_q <= DEVICE_ADDRESS_RESET;
      bcd_convert_q    <= BCD_CONVERT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_DEVICE_ADDRESS) begin
        device_address_q <= pwdata[6:0];
      end else begin
        bcd_convert_q <= pwdata[0];
      end
    end
  end

  assign s_axis_tready = !queue_full;
  assign push          = s_axis_tvalid && s_axis_tready;

  i2cra_front u_front (
    .op_i          (s_axis_tuser),
    .reg_addr_i    (s_axis_tdata[7:0]),
    .write_value_i (s_axis_tdata[15:8]),
    .sda_sample_i  (s_axis_tdata[16]),
    .bcd_convert_i (bcd_convert_q),
    .item_o        (front_item)
  );

  i2cra_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (front_item),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .empty_o     (queue_empty),
    .pop_item_o  (queue_item)
  );

  i2cra_engine u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (!queue_empty),
    .item_i           (queue_item),
    .item_pop_o       (queue_pop),
    .device_address_i (device_address_q),
    .bcd_convert_i    (bcd_convert_q),
    .m_valid_o        (m_axis_tvalid),
    .m_ready_i        (m_axis_tready),
    .m_data_o         (m_axis_tdata)
  );

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
    else $error("done reported while still busy");

  a_done_lines_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[0] && m_axis_tdata[1])
    else $error("lines not released after stop");

  a_read_zero_without_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[3] |-> m_axis_tdata[11:4] == 8'd0)
    else $error("read byte shown without done");

  a_queue_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_pop |-> !queue_empty)
    else $error("queue popped while empty");

endmodule

// ===== design/i2cra_front.sv =====
// ----------------------------------------------------------------------------
// I2C register access master front end
// Classifies an incoming item as command or tick and converts write data to BCD in BCD mode.
// ----------------------------------------------------------------------------
module i2cra_front
  import i2cra_pkg::*;
(
  input  logic [1:0] op_i,
  input  logic [7:0] reg_addr_i,
  input  logic [7:0] write_value_i,
  input  logic       sda_sample_i,
  input  logic       bcd_convert_i,
  output item_t      item_o
);

  logic [6:0]  sat;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [6:0]  ones;
  logic [7:0]  bcd_value;

  assign sat       = (write_value_i > {1'b0, BCD_MAX}) ? BCD_MAX : write_value_i[6:0];
  assign prod      = {8'd0, sat} * 15'd205;
  assign tens      = prod[14:11];
  assign tens_x10  = {tens, 3'd0} + {2'd0, tens, 1'b0};
  assign ones      = sat - tens_x10;
  assign bcd_value = {tens, ones[3:0]};

  always_comb begin
    item_o.is_cmd   = (op_i == OP_WRITE) || (op_i == OP_READ);
    item_o.is_read  = (op_i == OP_READ);
    item_o.reg_addr = reg_addr_i;
    item_o.value    = bcd_convert_i ? bcd_value : write_value_i;
    item_o.sda      = sda_sample_i;
  end

endmodule

// ===== design/i2cra_queue.sv =====
// ----------------------------------------------------------------------------
// I2C register access master queue
// Short first-in first-out queue between the front end and the bus engine.
// ----------------------------------------------------------------------------
module i2cra_queue
  import i2cra_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH_DEFAULT
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o     = (count_q == CntFull);
  assign empty_o    = (count_q == '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== design/i2cra_engine.sv =====
// ----------------------------------------------------------------------------
// I2C register access master bus engine
// Steps the bus sequence once per queued item and registers the result.
// ----------------------------------------------------------------------------
module i2cra_engine
  import i2cra_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  item_t       item_i,
  output logic        item_pop_o,
  input  logic [6:0]  device_address_i,
  input  logic        bcd_convert_i,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output logic [15:0] m_data_o
);

  localparam logic [4:0] PH_IDLE     = 5'd0;
  localparam logic [4:0] PH_START_A  = 5'd1;
  localparam logic [4:0] PH_START_B  = 5'd2;
  localparam logic [4:0] PH_WLOW     = 5'd3;
  localparam logic [4:0] PH_WHIGH    = 5'd4;
  localparam logic [4:0] PH_WTAIL    = 5'd5;
  localparam logic [4:0] PH_ACK_LOW  = 5'd6;
  localparam logic [4:0] PH_ACK_HIGH = 5'd7;
  localparam logic [4:0] PH_ACK_TAIL = 5'd8;
  localparam logic [4:0] PH_RHIGH    = 5'd9;
  localparam logic [4:0] PH_RLOW     = 5'd10;
  localparam logic [4:0] PH_STOP     = 5'd11;

  logic [4:0]  phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [7:0]  shift_q, shift_d;
  logic [1:0]  byte_q, byte_d;
  logic        is_read_q, is_read_d;
  logic [7:0]  held_reg_q, held_reg_d;
  logic [7:0]  held_val_q, held_val_d;
  logic        ack_q, ack_d;
  logic        m_valid_q;
  logic [15:0] m_data_q;

  logic [3:0]  cnt_inc;
  logic        done;
  logic        scl;
  logic        sda;
  logic [7:0]  masked;
  logic [7:0]  decoded;
  logic [7:0]  read_value;

  assign item_pop_o = item_valid_i && (!m_valid_q || m_ready_i);
  assign cnt_inc    = cnt_q + 4'd1;

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    shift_d    = shift_q;
    byte_d     = byte_q;
    is_read_d  = is_read_q;
    held_reg_d = held_reg_q;
    held_val_d = held_val_q;
    ack_d      = ack_q;
    done       = 1'b0;
    if (item_pop_o) begin
      if (item_i.is_cmd) begin
        if (phase_q == PH_IDLE) begin
          is_read_d  = item_i.is_read;
          held_reg_d = item_i.reg_addr;
          held_val_d = item_i.value;
          ack_d      = 1'b0;
          byte_d     = 2'd0;
          cnt_d      = 4'd0;
          shift_d    = 8'd0;
          phase_d    = PH_START_A;
        end
      end else begin
        unique case (phase_q)
          PH_START_A: phase_d = PH_START_B;
          PH_START_B: begin
            shift_d = {device_address_i, (byte_q == 2'd2)};
            cnt_d   = 4'd0;
            phase_d = PH_WLOW;
          end
          PH_WLOW:  phase_d = PH_WHIGH;
          PH_WHIGH: phase_d = PH_WTAIL;
          PH_WTAIL: begin
            shift_d = {shift_q[6:0], 1'b0};
            cnt_d   = cnt_inc;
            phase_d = cnt_inc[3] ? PH_ACK_LOW : PH_WLOW;
          end
          PH_ACK_LOW: phase_d = PH_ACK_HIGH;
          PH_ACK_HIGH: begin
            if (item_i.sda) begin
              ack_d = 1'b1;
            end
            phase_d = PH_ACK_TAIL;
          end
          PH_ACK_TAIL: begin
            if (byte_q == 2'd0) begin
              byte_d  = 2'd1;
              shift_d = held_reg_q;
              cnt_d   = 4'd0;
              phase_d = PH_WLOW;
            end else if (byte_q == 2'd1) begin
              byte_d = 2'd2;
              if (is_read_q) begin
                phase_d = PH_START_A;
              end else begin
                shift_d = held_val_q;
                cnt_d   = 4'd0;
                phase_d = PH_WLOW;
              end
            end else if (is_read_q) begin
              shift_d = 8'd0;
              cnt_d   = 4'd0;
              phase_d = PH_RHIGH;
            end else begin
              phase_d = PH_STOP;
            end
          end
          PH_RHIGH: begin
            shift_d = {shift_q[6:0], item_i.sda};
            phase_d = PH_RLOW;
          end
          PH_RLOW: begin
            cnt_d   = cnt_inc;
            phase_d = cnt_inc[3] ? PH_STOP : PH_RHIGH;
          end
          PH_STOP: begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    unique case (phase_d)
      PH_START_A:  begin scl = 1'b1; sda = 1'b1; end
      PH_START_B:  begin scl = 1'b1; sda = 1'b0; end
      PH_WLOW:     begin scl = 1'b0; sda = shift_d[7]; end
      PH_WHIGH:    begin scl = 1'b1; sda = shift_d[7]; end
      PH_WTAIL:    begin scl = 1'b0; sda = (cnt_d == 4'd7) ? 1'b1 : shift_d[7]; end
      PH_ACK_LOW:  begin scl = 1'b0; sda = 1'b1; end
      PH_ACK_HIGH: begin scl = 1'b1; sda = 1'b1; end
      PH_ACK_TAIL: begin scl = 1'b0; sda = 1'b1; end
      PH_RHIGH:    begin scl = 1'b1; sda = 1'b1; end
      PH_RLOW:     begin scl = 1'b0; sda = 1'b1; end
      PH_STOP:     begin scl = 1'b1; sda = 1'b0; end
      default:     begin scl = 1'b1; sda = 1'b1; end
    endcase
  end

  assign masked  = (held_reg_q == MASKED_REGISTER) ? (shift_q & MASKED_READ_BITS) : shift_q;
  assign decoded = {1'b0, masked[7:4], 3'd0} + {3'd0, masked[7:4], 1'b0} + {4'd0, masked[3:0]};

  always_comb begin
    read_value = 8'd0;
    if (done && is_read_q) begin
      read_value = bcd_convert_i ? decoded : shift_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      cnt_q      <= 4'd0;
      shift_q    <= 8'd0;
      byte_q     <= 2'd0;
      is_read_q  <= 1'b0;
      held_reg_q <= 8'd0;
      held_val_q <= 8'd0;
      ack_q      <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      shift_q    <= shift_d;
      byte_q     <= byte_d;
      is_read_q  <= is_read_d;
      held_reg_q <= held_reg_d;
      held_val_q <= held_val_d;
      ack_q      <= ack_d;
      if (item_pop_o) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      m_data_q <= {3'd0, ack_d, read_value, done, (phase_d != PH_IDLE), sda, scl};
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

endmodule
